/* hw/rtl/spq_pkg.sv */
// shared types and constants for the sorted priority queue
`default_nettype none
package spq_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;
    localparam int CNT_BITS_DEF = $clog2(DEPTH_DEF + 1);

    // input beat operation
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // result error codes
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;            // insert accepted this cycle
        logic ext;            // extract accepted this cycle
        logic largest_first;  // service order
    } t_cell_ctl;

endpackage
`default_nettype wire

/* hw/rtl/spq_if.sv */
// handshake interfaces for the item, result and configuration channels
`default_nettype none
interface spq_in_if #(
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic [KEY_BITS-1:0] item_key;
    logic [TAG_BITS-1:0] item_tag;

    modport source (output valid, mode, item_key, item_tag, input ready);
    modport sink   (input valid, mode, item_key, item_tag, output ready);
endinterface

interface spq_out_if #(
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS = spq_pkg::CNT_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                out_valid;
    logic [CNT_BITS-1:0] entry_count;
    logic                queue_empty;
    logic [1:0]          error_code;

    modport source (output valid, out_key, out_tag, out_valid, entry_count, queue_empty,
                    error_code, input ready);
    modport sink   (input valid, out_key, out_tag, out_valid, entry_count, queue_empty,
                    error_code, output ready);
endinterface

interface spq_cfg_if;
    logic valid;
    logic ready;
    logic largest_first;

    modport source (output valid, largest_first, input ready);
    modport sink   (input valid, largest_first, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sorted_priority_queue_top.sv */
// sorted priority queue: a chain of compare-and-shift cells with a registered result
// the result beat is registered and presented in the cycle after the item beat is accepted
// throughput: one insert or extract per cycle; every cell compares and shifts at once
// a result held back by the sink blocks new items until the cycle it is taken
// reset: synchronous active low; clears the entry count, the result valid and
// largest_first; entry storage is not cleared and needs no clearing pass
`default_nettype none
module sorted_priority_queue_top #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    spq_cfg_if.sink      i_cfg,
    spq_in_if.sink       i_item,
    spq_out_if.source    o_res
);

    logic                r_largest_first;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [TAG_BITS-1:0] r_out_tag;
    logic                r_out_real;
    logic [CNT_BITS-1:0] r_out_count;
    spq_pkg::t_err       r_out_err;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    spq_pkg::t_cell_ctl  ctl;
    spq_pkg::t_err       err;
    logic [KEY_BITS-1:0] res_key;
    logic [TAG_BITS-1:0] res_tag;
    logic                res_real;

    logic [DEPTH-1:0]    here;
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];

    // configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest_first <= 1'b0;
        end else if (i_cfg.valid) begin
            r_largest_first <= i_cfg.largest_first;
        end
    end

    // accept whenever the result register is free or draining
    assign i_item.ready = !r_out_valid || o_res.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign is_full      = (r_count == CNT_BITS'(DEPTH));
    assign is_empty     = (r_count == '0);

    assign ctl.ins = accept && (i_item.mode == spq_pkg::MODE_INSERT) && !is_full;
    assign ctl.ext = accept && (i_item.mode == spq_pkg::MODE_EXTRACT) && !is_empty;
    assign ctl.largest_first = r_largest_first;

    // chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                occ;
        logic                prev_here;
        logic [KEY_BITS-1:0] prev_key;
        logic [TAG_BITS-1:0] prev_tag;
        logic [KEY_BITS-1:0] next_key;
        logic [TAG_BITS-1:0] next_tag;

        assign occ = (r_count > CNT_BITS'(g));
        if (g == 0) begin : g_first
            assign prev_here = 1'b0;
            assign prev_key  = '0;
            assign prev_tag  = '0;
        end else begin : g_mid
            assign prev_here = here[g-1];
            assign prev_key  = cell_key[g-1];
            assign prev_tag  = cell_tag[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_key = '0;
            assign next_tag = '0;
        end else begin : g_inner
            assign next_key = cell_key[g+1];
            assign next_tag = cell_tag[g+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occ),
            .i_new_key   (i_item.item_key),
            .i_new_tag   (i_item.item_tag),
            .i_prev_here (prev_here),
            .i_prev_key  (prev_key),
            .i_prev_tag  (prev_tag),
            .i_next_key  (next_key),
            .i_next_tag  (next_tag),
            .o_here      (here[g]),
            .o_key       (cell_key[g]),
            .o_tag       (cell_tag[g])
        );
    end

    // result fields and next count
    always_comb begin
        n_count  = r_count;
        err      = spq_pkg::ERR_OK;
        res_key  = cell_key[0];
        res_tag  = cell_tag[0];
        res_real = 1'b1;
        if (i_item.mode == spq_pkg::MODE_EXTRACT) begin
            if (is_empty) begin
                err      = spq_pkg::ERR_EMPTY;
                res_key  = '0;
                res_tag  = '0;
                res_real = 1'b0;
            end else begin
                n_count = r_count - CNT_BITS'(1);
            end
        end else begin
            if (is_full) begin
                err = spq_pkg::ERR_FULL;
            end else begin
                n_count = r_count + CNT_BITS'(1);
                if (here[0]) begin
                    res_key = i_item.item_key;
                    res_tag = i_item.item_tag;
                end
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_key   <= res_key;
            r_out_tag   <= res_tag;
            r_out_real  <= res_real;
            r_out_count <= n_count;
            r_out_err   <= err;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_key     = r_out_key;
    assign o_res.out_tag     = r_out_tag;
    assign o_res.out_valid   = r_out_real;
    assign o_res.entry_count = r_out_count;
    assign o_res.queue_empty = (r_out_count == '0);
    assign o_res.error_code  = r_out_err;

endmodule
`default_nettype wire

/* hw/rtl/spq_cell.sv */
// one cell of the sorted chain: holds one entry, compares and shifts
`default_nettype none
module spq_cell #(
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire                   i_occupied,
    input  wire [KEY_BITS-1:0]    i_new_key,
    input  wire [TAG_BITS-1:0]    i_new_tag,
    input  wire                   i_prev_here,
    input  wire [KEY_BITS-1:0]    i_prev_key,
    input  wire [TAG_BITS-1:0]    i_prev_tag,
    input  wire [KEY_BITS-1:0]    i_next_key,
    input  wire [TAG_BITS-1:0]    i_next_tag,
    output logic                  o_here,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [TAG_BITS-1:0]   o_tag
);

    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;
    logic                better;

    // new key goes strictly ahead of the stored one
    assign better = i_ctl.largest_first ? (i_new_key > r_key) : (i_new_key < r_key);
    // insert point lies here or in an earlier cell
    assign o_here = i_prev_here || !i_occupied || better;

    // keep, take the new entry, or take a neighbor's entry
    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ext) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end else if (i_ctl.ins) begin
            if (i_prev_here) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else if (o_here) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule
`default_nettype wire

/* sim/spq_order_checker.sv */
// checker for the sorted priority queue: tracks the stored entries and compares result beats
module spq_order_checker #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  wire i_clk,
    input  wire i_rst_n,
    spq_cfg_if  i_cfg,
    spq_in_if   i_item,
    spq_out_if  i_res,
    output int  o_fail_count,
    output int  o_pending
);

    import spq_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                out_valid;
        logic [CNT_BITS-1:0] count;
        logic                empty;
        t_err                err;
    } t_result;

    // shadow of the queue contents, position 0 is served next
    logic [KEY_BITS-1:0] entry_keys [DEPTH];
    logic [TAG_BITS-1:0] entry_tags [DEPTH];
    int                  entry_total = 0;
    logic                serve_largest = 1'b0;

    t_result due_results [$];
    int      mismatches = 0;
    int      waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // true when key a leaves strictly ahead of key b
    function automatic logic leaves_ahead(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
        return serve_largest ? (a > b) : (a < b);
    endfunction

    // apply one item beat to the shadow queue and return the result it should produce
    function automatic t_result queue_step(logic m, logic [KEY_BITS-1:0] k,
                                           logic [TAG_BITS-1:0] t);
        t_result r;
        int      pos;
        int      i;
        r = '0;
        r.err = ERR_OK;
        if (m == MODE_EXTRACT) begin
            if (entry_total == 0) begin
                r.err = ERR_EMPTY;
            end else begin
                r.key = entry_keys[0];
                r.tag = entry_tags[0];
                r.out_valid = 1'b1;
                for (i = 1; i < entry_total; i++) begin
                    entry_keys[i-1] = entry_keys[i];
                    entry_tags[i-1] = entry_tags[i];
                end
                entry_total--;
            end
        end else if (entry_total >= DEPTH) begin
            // full: nothing stored, current head reported
            r.key = entry_keys[0];
            r.tag = entry_tags[0];
            r.out_valid = 1'b1;
            r.err = ERR_FULL;
        end else begin
            // new entry goes behind every entry that is not worse
            pos = 0;
            while (pos < entry_total && !leaves_ahead(k, entry_keys[pos]))
                pos++;
            for (i = entry_total; i > pos; i--) begin
                entry_keys[i] = entry_keys[i-1];
                entry_tags[i] = entry_tags[i-1];
            end
            entry_keys[pos] = k;
            entry_tags[pos] = t;
            entry_total++;
            r.key = entry_keys[0];
            r.tag = entry_tags[0];
            r.out_valid = 1'b1;
        end
        r.count = CNT_BITS'(entry_total);
        r.empty = (entry_total == 0);
        return r;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            report($sformatf("%s expected %0h, got %0h", what, want, got));
    endtask

    // watch every channel at the clock edge
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            entry_total = 0;
            serve_largest = 1'b0;
            due_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                serve_largest = i_cfg.largest_first;

            // result beat against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                if (due_results.size() == 0) begin
                    report($sformatf("result beat with nothing expected, key %0h tag %0h",
                                     i_res.out_key, i_res.out_tag));
                end else begin
                    want = due_results.pop_front();
                    check_field("out_key", want.key, i_res.out_key);
                    check_field("out_tag", want.tag, i_res.out_tag);
                    check_field("out_valid", want.out_valid, i_res.out_valid);
                    check_field("entry_count", want.count, i_res.entry_count);
                    check_field("queue_empty", want.empty, i_res.queue_empty);
                    check_field("error_code", want.err, i_res.error_code);
                end
            end

            if (i_item.valid && i_item.ready)
                due_results.push_back(queue_step(i_item.mode, i_item.item_key,
                                                 i_item.item_tag));
        end
        waiting = due_results.size();
    end

endmodule

/* sim/sorted_priority_queue_top_tb.sv */
// testbench top for the sorted priority queue: clock, reset, stimulus and verdict
module sorted_priority_queue_top_tb;

    import spq_pkg::*;

    localparam int KB = KEY_BITS_DEF;
    localparam int TB = TAG_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    // per-phase idling odds, in percent
    int gap_pct = 0;
    int stall_pct = 0;

    spq_cfg_if cfg_bus ();
    spq_in_if  item_bus ();
    spq_out_if res_bus ();

    sorted_priority_queue_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_item  (item_bus),
        .o_res   (res_bus)
    );

    spq_order_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_bus),
        .i_item       (item_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    // run limit
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: ready with stall bursts
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
        end
    end

    // one item beat, with an occasional gap ahead of it
    task automatic send_item(logic m, logic [KB-1:0] k, logic [TB-1:0] t);
        if ($urandom_range(0, 99) < gap_pct) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.mode     <= m;
        item_bus.item_key <= k;
        item_bus.item_tag <= t;
        do @(posedge clk); while (!item_bus.ready);
    endtask

    // stop sending and wait until every result beat has come back
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_order(logic lf);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.largest_first <= lf;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          ph;
        int          insert_pct;
        logic [KB-1:0] rand_key;
        logic [TB-1:0] rand_tag;
        logic          rand_mode;

        rst_n                 <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.largest_first <= 1'b0;
        item_bus.valid        <= 1'b0;
        item_bus.mode         <= MODE_INSERT;
        item_bus.item_key     <= '0;
        item_bus.item_tag     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest first: empty extract, extremes, equal keys in arrival order
        write_order(1'b0);
        send_item(MODE_EXTRACT, '0, '0);
        send_item(MODE_INSERT, '1, '1);
        send_item(MODE_INSERT, '0, '0);
        send_item(MODE_INSERT, KB'(5), 16'h0001);
        send_item(MODE_INSERT, KB'(5), 16'h0002);
        send_item(MODE_INSERT, KB'(5), 16'h0003);
        repeat (6) send_item(MODE_EXTRACT, '1, '1);

        // largest first with the same extremes
        wait_drained();
        write_order(1'b1);
        send_item(MODE_INSERT, '0, 16'hAAAA);
        send_item(MODE_INSERT, KB'(7), 16'h5555);
        send_item(MODE_INSERT, '1, 16'h00FF);
        send_item(MODE_INSERT, KB'(7), 16'hFF00);
        repeat (5) send_item(MODE_EXTRACT, '0, '0);

        // random phases: filling, draining and balanced mixes
        for (ph = 0; ph < 10; ph++) begin
            wait_drained();
            write_order(1'(ph == 9 ? 0 : $urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 3;
                2: gap_pct = 10;
                default: gap_pct = 25;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 3;
                2: stall_pct = 10;
                default: stall_pct = 25;
            endcase
            // no idling in the closing phase
            if (ph == 9) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            case (ph % 3)
                0: insert_pct = 80;
                1: insert_pct = 25;
                default: insert_pct = 55;
            endcase
            repeat (200) begin
                rand_mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_EXTRACT;
                // narrow ranges make equal keys common
                case ($urandom_range(0, 3))
                    0: rand_key = KB'($urandom_range(0, 7));
                    1: rand_key = ~(KB'($urandom_range(0, 7)));
                    default: rand_key = KB'($urandom());
                endcase
                rand_tag = TB'($urandom());
                send_item(rand_mode, rand_key, rand_tag);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
sim/spq_order_checker.sv
sim/sorted_priority_queue_top_tb.sv
